// ===== hw/rtl/crc_checked_frame_hunter_defines.svh =====
`ifndef CRC_CHECKED_FRAME_HUNTER_DEFINES_SVH
`define CRC_CHECKED_FRAME_HUNTER_DEFINES_SVH

// checked while out of reset
`define CFH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define CFH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/cfh_pkg.sv =====
`timescale 1ns / 1ps

package cfh_pkg;

  localparam int MAX_FRAME_DEF = 8;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  localparam int OP_W   = 2;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_LENGTH  = 3'd0,
    REG_PREFIX_LENGTH = 3'd1,
    REG_PREFIX_FIRST  = 3'd2,
    REG_PREFIX_SECOND = 3'd3,
    REG_TIMEOUT_TICKS = 3'd4
  } reg_idx_t;

  localparam logic KIND_FRAME   = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  localparam logic [3:0]  FRAME_LENGTH_RST  = 4'd3;
  localparam logic [1:0]  PREFIX_LENGTH_RST = 2'd1;
  localparam logic [7:0]  PREFIX_FIRST_RST  = 8'd0;
  localparam logic [7:0]  PREFIX_SECOND_RST = 8'd0;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd20;

  typedef struct packed {
    logic shift;
    logic load;
    logic eshift;
  } cell_ctl_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 8'd0) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/cfh_in_if.sv =====
`timescale 1ns / 1ps

interface cfh_in_if;
  logic                       valid;
  logic                       ready;
  logic [cfh_pkg::OP_W-1:0]   operation;
  logic [7:0]                 rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

// ===== hw/rtl/cfh_out_if.sv =====
`timescale 1ns / 1ps

interface cfh_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] frame_byte;
  logic       last;

  modport source (output valid, output kind, output frame_byte, output last, input ready);
  modport sink (input valid, input kind, input frame_byte, input last, output ready);
endinterface

// ===== hw/rtl/cfh_cfg_if.sv =====
`timescale 1ns / 1ps

interface cfh_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cfh_pkg::IDX_W-1:0]    index;
  logic [cfh_pkg::DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/crc_checked_frame_hunter.sv =====
`timescale 1ns / 1ps

// channel | dir | payload                         | transfer
// in_s    | in  | operation, rx_byte              | valid & ready
// out_s   | out | kind, frame_byte, last          | valid & ready
// cfg_s   | in  | index, data                     | valid & ready (ready held high)
//
// bytes, ticks and restarts may follow back to back while no result is pending
// a matched frame of n bytes is shifted out of the cell chain byte by byte; input is
// held until its last byte transfers, and taken again in that same cycle
// a timeout result is a single transfer and holds the input in the same way
// reset is synchronous: counters and config registers return to their defaults; the cells are not reset
// out_ready low holds the pending result and, with it, the input side

module crc_checked_frame_hunter #(
  parameter int MAX_FRAME = cfh_pkg::MAX_FRAME_DEF
) (
  input logic          clk,
  input logic          rst_n,
  cfh_in_if.sink       in_s,
  cfh_out_if.source    out_s,
  cfh_cfg_if.sink      cfg_s
);

  localparam int LW = $clog2(MAX_FRAME + 1);
  localparam int IW = $clog2(MAX_FRAME);

  logic [3:0]  frame_length_r;
  logic [1:0]  prefix_length_r;
  logic [7:0]  prefix_first_r;
  logic [7:0]  prefix_second_r;
  logic [15:0] timeout_ticks_r;

  logic [LW-1:0] fill_r, fill_nxt, fill_inc;
  logic [15:0]   idle_r, idle_nxt, idle_inc;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          kind_r, kind_nxt;

  logic [7:0] win_w     [MAX_FRAME];
  logic [7:0] crc_w     [MAX_FRAME];
  logic [7:0] emit_w    [MAX_FRAME];
  logic [7:0] byte_in_w [MAX_FRAME];
  logic [7:0] crc_in_w  [MAX_FRAME];
  logic [7:0] emit_in_w [MAX_FRAME];

  cfh_pkg::cell_ctl_t ctl;

  logic [LW-1:0] len;
  logic [IW-1:0] idx_crc, idx_second, idx_head;
  logic [7:0]    sel_crc, sel_first, sel_second, head;
  logic          match, in_xfer, out_xfer;

  for (genvar k = 0; k < MAX_FRAME; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign byte_in_w[k] = in_s.rx_byte;
      assign crc_in_w[k]  = 8'd0;
      assign emit_in_w[k] = 8'd0;
    end else begin : g_next
      assign byte_in_w[k] = win_w[k-1];
      assign crc_in_w[k]  = crc_w[k-1];
      assign emit_in_w[k] = emit_w[k-1];
    end
    cfh_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .new_byte (in_s.rx_byte),
      .byte_in  (byte_in_w[k]),
      .crc_in   (crc_in_w[k]),
      .emit_in  (emit_in_w[k]),
      .win_byte (win_w[k]),
      .crc_out  (crc_w[k]),
      .emit_out (emit_w[k])
    );
  end

  always_comb begin
    if (frame_length_r < 4'd3) begin
      len = LW'(3);
    end else if (int'(frame_length_r) > MAX_FRAME) begin
      len = LW'(MAX_FRAME);
    end else begin
      len = LW'(frame_length_r);
    end
  end

  assign idx_crc    = IW'(len - LW'(2));
  assign idx_second = IW'(len - LW'(3));
  assign idx_head   = IW'(len - LW'(1));

  always_comb begin
    sel_crc    = 8'd0;
    sel_first  = 8'd0;
    sel_second = 8'd0;
    head       = 8'd0;
    for (int k = 0; k < MAX_FRAME; k++) begin
      if (IW'(k) == idx_crc) begin
        sel_crc   = crc_w[k];
        sel_first = win_w[k];
      end
      if (IW'(k) == idx_second) begin
        sel_second = win_w[k];
      end
      if (IW'(k) == idx_head) begin
        head = emit_w[k];
      end
    end
  end

  assign fill_inc = (fill_r == LW'(MAX_FRAME)) ? fill_r : fill_r + LW'(1);
  assign idle_inc = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;

  assign match = (fill_inc >= len) && (sel_first == prefix_first_r)
               && (!prefix_length_r[1] || (sel_second == prefix_second_r))
               && (sel_crc == in_s.rx_byte);

  assign in_s.ready  = (cnt_r == '0) || ((cnt_r == LW'(1)) && out_s.ready);
  assign in_xfer     = in_s.valid && in_s.ready;
  assign out_xfer    = out_s.valid && out_s.ready;
  assign cfg_s.ready = 1'b1;

  always_comb begin
    fill_nxt   = fill_r;
    idle_nxt   = idle_r;
    kind_nxt   = kind_r;
    cnt_nxt    = out_xfer ? cnt_r - LW'(1) : cnt_r;
    ctl        = '0;
    ctl.eshift = out_xfer;
    if (in_xfer) begin
      case (in_s.operation)
        cfh_pkg::OP_BYTE: begin
          ctl.shift = 1'b1;
          idle_nxt  = 16'd0;
          if (match) begin
            ctl.load = 1'b1;
            fill_nxt = '0;
            cnt_nxt  = len;
            kind_nxt = cfh_pkg::KIND_FRAME;
          end else begin
            fill_nxt = fill_inc;
          end
        end
        cfh_pkg::OP_TICK: begin
          if (idle_inc >= timeout_ticks_r) begin
            fill_nxt = '0;
            idle_nxt = 16'd0;
            cnt_nxt  = LW'(1);
            kind_nxt = cfh_pkg::KIND_TIMEOUT;
          end else begin
            idle_nxt = idle_inc;
          end
        end
        cfh_pkg::OP_RESTART: begin
          fill_nxt = '0;
          idle_nxt = 16'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      idle_r <= 16'd0;
      cnt_r  <= '0;
      kind_r <= cfh_pkg::KIND_FRAME;
    end else begin
      fill_r <= fill_nxt;
      idle_r <= idle_nxt;
      cnt_r  <= cnt_nxt;
      kind_r <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r  <= cfh_pkg::FRAME_LENGTH_RST;
      prefix_length_r <= cfh_pkg::PREFIX_LENGTH_RST;
      prefix_first_r  <= cfh_pkg::PREFIX_FIRST_RST;
      prefix_second_r <= cfh_pkg::PREFIX_SECOND_RST;
      timeout_ticks_r <= cfh_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_s.valid && cfg_s.ready) begin
      case (cfg_s.index)
        cfh_pkg::REG_FRAME_LENGTH:  frame_length_r  <= cfg_s.data[3:0];
        cfh_pkg::REG_PREFIX_LENGTH: prefix_length_r <= cfg_s.data[1:0];
        cfh_pkg::REG_PREFIX_FIRST:  prefix_first_r  <= cfg_s.data[7:0];
        cfh_pkg::REG_PREFIX_SECOND: prefix_second_r <= cfg_s.data[7:0];
        cfh_pkg::REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_s.data[15:0];
        default: ;
      endcase
    end
  end

  assign out_s.valid      = (cnt_r != '0);
  assign out_s.kind       = kind_r;
  assign out_s.frame_byte = (kind_r == cfh_pkg::KIND_TIMEOUT) ? 8'd0 : head;
  assign out_s.last       = (cnt_r == LW'(1));

endmodule

// ===== hw/rtl/cfh_cell.sv =====
`timescale 1ns / 1ps

module cfh_cell (
  input  logic                clk,
  input  cfh_pkg::cell_ctl_t  ctl,
  input  logic [7:0]          new_byte,
  input  logic [7:0]          byte_in,
  input  logic [7:0]          crc_in,
  input  logic [7:0]          emit_in,
  output logic [7:0]          win_byte,
  output logic [7:0]          crc_out,
  output logic [7:0]          emit_out
);

  logic [7:0] win_r;
  logic [7:0] crc_r;
  logic [7:0] emit_r;

  // crc over the bytes from this cell down to the newest one
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win_r <= byte_in;
      crc_r <= cfh_pkg::crc_byte(crc_in, new_byte);
    end
    if (ctl.load) begin
      emit_r <= byte_in;
    end else if (ctl.eshift) begin
      emit_r <= emit_in;
    end
  end

  assign win_byte = win_r;
  assign crc_out  = crc_r;
  assign emit_out = emit_r;

endmodule

// ===== hw/rtl/cfh_checker.sv =====
`timescale 1ns / 1ps
`include "crc_checked_frame_hunter_defines.svh"

module cfh_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [7:0] out_frame_byte,
  input logic       out_last
);

  `CFH_ASSERT_ALWAYS(a_idle_after_reset, !rst_n |=> !out_valid, "result pending after reset")

  `CFH_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_frame_byte) && $stable(out_last), "stalled result changed")

  `CFH_ASSERT(a_busy_blocks_input, out_valid && !out_last |-> !in_ready, "input taken mid frame")

  `CFH_ASSERT(a_timeout_shape, out_valid && out_kind |-> out_last && (out_frame_byte == 8'd0), "malformed timeout result")

endmodule

bind crc_checked_frame_hunter cfh_checker u_cfh_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_s.ready),
  .out_valid      (out_s.valid),
  .out_ready      (out_s.ready),
  .out_kind       (out_s.kind),
  .out_frame_byte (out_s.frame_byte),
  .out_last       (out_s.last)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WIN_DEPTH = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int HUNT_PHASE_ITEMS = 32;

  typedef struct packed {
    logic       kind;
    logic [7:0] frame_byte;
    logic       last;
  } hunt_result_t;

  logic clk = 1'b0;
  logic rst_n;

  cfh_in_if  byte_ch ();
  cfh_out_if hunt_ch ();
  cfh_cfg_if reg_ch ();

  crc_checked_frame_hunter u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (byte_ch),
    .out_s (hunt_ch),
    .cfg_s (reg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  hunt_result_t pending_results[$];
  int unsigned  cycle_count = 0;
  int unsigned  mismatches = 0;
  int           in_gap_pct = 29;
  int           out_stall_pct = 29;
  int           hold_left = 0;

  // model of the hunter
  logic [7:0]  win_bytes [0:WIN_DEPTH-1];
  int          win_fill;
  logic [15:0] idle_count;
  logic [3:0]  reg_frame_len;
  logic [1:0]  reg_prefix_len;
  logic [7:0]  reg_prefix_a;
  logic [7:0]  reg_prefix_b;
  logic [15:0] reg_timeout;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] value);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ value[i];
      c = {c[6:0], 1'b0} ^ (fb ? cfh_pkg::CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic int eff_frame_len();
    if (reg_frame_len < 4'd3) return 3;
    if (reg_frame_len > 4'(WIN_DEPTH)) return WIN_DEPTH;
    return int'(reg_frame_len);
  endfunction

  function automatic int eff_prefix_len();
    if (reg_prefix_len == 2'd0) return 1;
    if (reg_prefix_len == 2'd3) return 2;
    return int'(reg_prefix_len);
  endfunction

  function automatic void clear_window();
    for (int k = 0; k < WIN_DEPTH; k++) win_bytes[k] = 8'h00;
    win_fill = 0;
    idle_count = 16'd0;
  endfunction

  function automatic void hunt_step(input logic [1:0] op, input logic [7:0] value);
    logic [7:0]   fr [0:WIN_DEPTH-1];
    logic [7:0]   crc;
    int           len;
    bit           hit;
    hunt_result_t res;
    case (op)
      cfh_pkg::OP_RESTART: begin
        clear_window();
      end
      cfh_pkg::OP_TICK: begin
        if (idle_count != 16'hFFFF) idle_count = idle_count + 16'd1;
        if (idle_count >= reg_timeout) begin
          clear_window();
          res.kind = cfh_pkg::KIND_TIMEOUT;
          res.frame_byte = 8'h00;
          res.last = 1'b1;
          pending_results.push_back(res);
        end
      end
      cfh_pkg::OP_BYTE: begin
        for (int k = WIN_DEPTH - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
        win_bytes[0] = value;
        if (win_fill < WIN_DEPTH) win_fill++;
        idle_count = 16'd0;
        len = eff_frame_len();
        if (win_fill >= len) begin
          for (int k = 0; k < len; k++) fr[k] = win_bytes[len-1-k];
          hit = (fr[0] == reg_prefix_a) && (eff_prefix_len() == 1 || fr[1] == reg_prefix_b);
          crc = 8'h00;
          for (int k = 0; k < len - 1; k++) crc = crc8_update(crc, fr[k]);
          if (hit && fr[len-1] == crc) begin
            for (int k = 0; k < len; k++) begin
              res.kind = cfh_pkg::KIND_FRAME;
              res.frame_byte = fr[k];
              res.last = (k == len - 1);
              pending_results.push_back(res);
            end
            clear_window();
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin : check_results
    hunt_result_t want;
    if (rst_n && hunt_ch.valid && hunt_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0b byte %02h last %0b",
                                  hunt_ch.kind, hunt_ch.frame_byte, hunt_ch.last));
      end else begin
        want = pending_results.pop_front();
        if (hunt_ch.kind !== want.kind)
          report_mismatch($sformatf("kind %0b, want %0b", hunt_ch.kind, want.kind));
        if (hunt_ch.frame_byte !== want.frame_byte)
          report_mismatch($sformatf("frame_byte %02h, want %02h",
                                    hunt_ch.frame_byte, want.frame_byte));
        if (hunt_ch.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", hunt_ch.last, want.last));
      end
    end
  end

  // result receiver, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hunt_ch.ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      hunt_ch.ready = ($urandom_range(99) >= out_stall_pct);
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] value);
    while ($urandom_range(99) < in_gap_pct) begin
      byte_ch.valid = 1'b0;
      @(negedge clk);
    end
    byte_ch.valid = 1'b1;
    byte_ch.operation = op;
    byte_ch.rx_byte = value;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    hunt_step(op, value);
    @(negedge clk);
  endtask

  task automatic settle();
    byte_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfh_pkg::reg_idx_t idx, input logic [15:0] value);
    reg_ch.valid = 1'b1;
    reg_ch.index = idx;
    reg_ch.data = value;
    @(posedge clk);
    while (!reg_ch.ready) @(posedge clk);
    case (idx)
      cfh_pkg::REG_FRAME_LENGTH:  reg_frame_len = value[3:0];
      cfh_pkg::REG_PREFIX_LENGTH: reg_prefix_len = value[1:0];
      cfh_pkg::REG_PREFIX_FIRST:  reg_prefix_a = value[7:0];
      cfh_pkg::REG_PREFIX_SECOND: reg_prefix_b = value[7:0];
      cfh_pkg::REG_TIMEOUT_TICKS: reg_timeout = value;
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  task automatic apply_config(input logic [15:0] frame_len, input logic [15:0] prefix_len,
                              input logic [15:0] prefix_a, input logic [15:0] prefix_b,
                              input logic [15:0] timeout);
    settle();
    write_reg(cfh_pkg::REG_FRAME_LENGTH, frame_len);
    write_reg(cfh_pkg::REG_PREFIX_LENGTH, prefix_len);
    write_reg(cfh_pkg::REG_PREFIX_FIRST, prefix_a);
    write_reg(cfh_pkg::REG_PREFIX_SECOND, prefix_b);
    write_reg(cfh_pkg::REG_TIMEOUT_TICKS, timeout);
    reg_ch.valid = 1'b0;
  endtask

  // well-formed frame for the current settings, optionally with a bad crc
  task automatic send_frame(input bit spoil);
    logic [7:0] fb [0:WIN_DEPTH-1];
    logic [7:0] crc;
    int         len;
    len = eff_frame_len();
    for (int k = 0; k < len - 1; k++) fb[k] = 8'($urandom);
    fb[0] = reg_prefix_a;
    if (eff_prefix_len() == 2) fb[1] = reg_prefix_b;
    crc = 8'h00;
    for (int k = 0; k < len - 1; k++) crc = crc8_update(crc, fb[k]);
    fb[len-1] = spoil ? crc ^ 8'($urandom_range(1, 255)) : crc;
    for (int k = 0; k < len; k++) send_item(cfh_pkg::OP_BYTE, fb[k]);
  endtask

  task automatic test_reset_defaults();
    send_item(cfh_pkg::OP_BYTE, 8'h00);
    send_item(cfh_pkg::OP_BYTE, 8'hFF);
    send_item(cfh_pkg::OP_BYTE, crc8_update(crc8_update(8'h00, 8'h00), 8'hFF));
    send_item(cfh_pkg::OP_BYTE, 8'h00);
    send_item(cfh_pkg::OP_BYTE, 8'h12);
    send_item(cfh_pkg::OP_RESTART, 8'hA5);
    send_item(cfh_pkg::OP_BYTE, crc8_update(crc8_update(8'h00, 8'h00), 8'h12));
    send_item(cfh_pkg::OP_BYTE, 8'h00);
    send_item(OP_UNUSED, 8'hAA);
    send_item(cfh_pkg::OP_BYTE, 8'h34);
    send_item(cfh_pkg::OP_BYTE, crc8_update(crc8_update(8'h00, 8'h00), 8'h34));
  endtask

  task automatic test_timeouts();
    apply_config(16'd3, 16'd1, 16'd0, 16'd0, 16'd0);
    send_item(cfh_pkg::OP_TICK, 8'h00);
    apply_config(16'd3, 16'd1, 16'd0, 16'd0, 16'd3);
    send_item(cfh_pkg::OP_RESTART, 8'h00);
    send_item(cfh_pkg::OP_TICK, 8'h00);
    send_item(cfh_pkg::OP_TICK, 8'h00);
    send_item(cfh_pkg::OP_BYTE, 8'h42);
    send_item(cfh_pkg::OP_TICK, 8'h00);
    send_item(cfh_pkg::OP_TICK, 8'h00);
    send_item(cfh_pkg::OP_RESTART, 8'h00);
    send_item(cfh_pkg::OP_TICK, 8'h00);
    send_item(cfh_pkg::OP_TICK, 8'h00);
    send_item(cfh_pkg::OP_TICK, 8'h00);
  endtask

  task automatic test_prefix_and_length();
    apply_config(16'd8, 16'd2, 16'h00FF, 16'h0000, 16'd20);
    send_item(cfh_pkg::OP_BYTE, 8'hFF);
    send_frame(1'b0);
    apply_config(16'd15, 16'd3, 16'h00A5, 16'h005A, 16'd20);
    send_frame(1'b0);
    apply_config(16'd0, 16'd0, 16'h00FF, 16'h0000, 16'd20);
    send_frame(1'b0);
    apply_config(16'd2, 16'd2, 16'h0011, 16'h0022, 16'd20);
    send_frame(1'b1);
    send_frame(1'b0);
  endtask

  task automatic test_longest_timeout();
    apply_config(16'd3, 16'd1, 16'd0, 16'd0, 16'hFFFF);
    in_gap_pct = 0;
    send_item(cfh_pkg::OP_RESTART, 8'h00);
    repeat (20) send_item(cfh_pkg::OP_TICK, 8'($urandom));
    in_gap_pct = 29;
  endtask

  task automatic test_backpressure();
    apply_config(16'd8, 16'd1, 16'h003C, 16'd0, 16'd20);
    hold_left = 150;
    in_gap_pct = 0;
    repeat (5) send_frame(1'b0);
    in_gap_pct = 29;
  endtask

  task automatic run_hunt_phase(input int n_items);
    int done;
    int pick;
    int n;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_frame($urandom_range(7) == 0);
        done += eff_frame_len();
      end else if (pick < 75) begin
        send_item(cfh_pkg::OP_BYTE,
                  ($urandom_range(1) == 0) ? reg_prefix_a : 8'($urandom));
        done++;
      end else if (pick < 88) begin
        n = $urandom_range(1, 4);
        repeat (n) send_item(cfh_pkg::OP_TICK, 8'($urandom));
        done += n;
      end else if (pick < 95) begin
        send_item(cfh_pkg::OP_RESTART, 8'($urandom));
        done++;
      end else begin
        send_item(OP_UNUSED, 8'($urandom));
      end
    end
  endtask

  task automatic test_random_hunt();
    logic [31:0] r;
    logic [15:0] tmo;
    apply_config(16'hFFF8, 16'h0002, 16'h12FF, 16'hFF00, 16'd1);
    run_hunt_phase(HUNT_PHASE_ITEMS);
    apply_config(16'd3, 16'd1, 16'd0, 16'd0, 16'hFFFF);
    run_hunt_phase(HUNT_PHASE_ITEMS);
    for (int p = 0; p < 4; p++) begin
      r = $urandom;
      tmo = ($urandom_range(1) == 0) ? 16'($urandom_range(0, 6)) : 16'($urandom);
      apply_config({r[15:4], 4'($urandom_range(15))}, {r[31:18], 2'($urandom_range(3))},
                   16'($urandom), 16'($urandom), tmo);
      if (p == 1) begin
        in_gap_pct = 0;
        out_stall_pct = 0;
      end
      run_hunt_phase(HUNT_PHASE_ITEMS);
      in_gap_pct = 29;
      out_stall_pct = 29;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.operation = cfh_pkg::OP_BYTE;
    byte_ch.rx_byte = 8'h00;
    reg_ch.valid = 1'b0;
    reg_ch.index = cfh_pkg::REG_FRAME_LENGTH;
    reg_ch.data = 16'd0;
    hunt_ch.ready = 1'b0;
    reg_frame_len = cfh_pkg::FRAME_LENGTH_RST;
    reg_prefix_len = cfh_pkg::PREFIX_LENGTH_RST;
    reg_prefix_a = cfh_pkg::PREFIX_FIRST_RST;
    reg_prefix_b = cfh_pkg::PREFIX_SECOND_RST;
    reg_timeout = cfh_pkg::TIMEOUT_TICKS_RST;
    clear_window();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_timeouts();
    test_prefix_and_length();
    test_longest_timeout();
    test_backpressure();
    test_random_hunt();
    settle();
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cfh_pkg.sv
hw/rtl/cfh_in_if.sv
hw/rtl/cfh_out_if.sv
hw/rtl/cfh_cfg_if.sv
hw/rtl/cfh_cell.sv
hw/rtl/crc_checked_frame_hunter.sv
hw/rtl/cfh_checker.sv
bench/testbench.sv
